@@ hdl/quadrature_speed_pi_regulator_assert.svh @@
// Assertion macros for the quadrature speed regulator.
// Used by the top level only; depends on nothing else.
`ifndef QUADRATURE_SPEED_PI_REGULATOR_ASSERT_SVH
`define QUADRATURE_SPEED_PI_REGULATOR_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define QSPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, checked outside reset.
`define QSPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/qspr_pkg.sv @@
// Shared constants, types and the microcode program of the speed regulator.
// Used by qspr_useq, qspr_dpath and quadrature_speed_pi_regulator.
package qspr_pkg;

    // Fixed scaling of the regulator.
    localparam int FRAC_BITS      = 8;
    localparam int TICK_RATE_HZ   = 2;
    localparam int COUNTS_PER_REV = 100;
    localparam int SEC_PER_MIN    = 60;

    // Field widths.
    localparam int CNT_W  = 8;
    localparam int SPD_W  = 9;
    localparam int REG_W  = 8;
    localparam int CFGI_W = 2;
    localparam int I_W    = 32;

    // Speed = count * TICK * 60 / CPR, done as one multiply by a scaled reciprocal.
    // The shift is large enough that the truncated result is exact for every count.
    localparam int SPD_SHIFT = 22;
    localparam int SPD_RECIP = ((1 << SPD_SHIFT) + COUNTS_PER_REV - 1) / COUNTS_PER_REV;
    localparam int SPD_K     = TICK_RATE_HZ * SEC_PER_MIN * SPD_RECIP;
    localparam int SPD_K_W   = $clog2(SPD_K + 1);
    localparam int PROD_W    = CNT_W + SPD_K_W;

    // Datapath widths.
    localparam int ERR_W   = SPD_W + 1;
    localparam int PE_W    = ERR_W + REG_W;
    localparam int SUM_W   = I_W + 1;
    localparam int V_W     = SUM_W - FRAC_BITS;
    localparam int D_W     = V_W + 1;
    localparam int TM_W    = D_W + REG_W + 1;
    localparam int M_W     = TM_W + 1;
    localparam int DIV_W   = M_W + FRAC_BITS;
    localparam int DIVR_W  = REG_W + 1;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int ACC_W   = DIV_W + 2;

    // Codes.
    localparam logic             OPC_SAMPLE = 1'b0;
    localparam logic             OPC_TICK   = 1'b1;
    localparam logic [1:0]       QD_UP      = 2'b01;
    localparam logic [1:0]       QD_DOWN    = 2'b10;
    localparam logic [CFGI_W-1:0] CFG_REF   = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_GAIN  = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_TI    = 2'd2;
    localparam logic [REG_W-1:0] DRIVE_MAX  = 8'd255;

    // Reset values of the registers.
    localparam logic [REG_W-1:0] REF_RST  = 8'd0;
    localparam logic [REG_W-1:0] GAIN_RST = 8'd2;
    localparam logic [REG_W-1:0] TI_RST   = 8'd1;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_SPD,
        OP_ERR,
        OP_PE,
        OP_VSUM,
        OP_VDIV,
        OP_CLAMP,
        OP_TMUL,
        OP_MSUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_INC,
        OP_SAT
    } t_op;

    // Sequencing of a control word.
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOOP_DIV,
        JMP_EMIT
    } t_jmp;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_DIV  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd11;

    typedef struct packed {
        t_op               op;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic fire;
        t_op  op;
    } t_ctrl;

    typedef struct packed {
        logic div_more;
    } t_dp_stat;

    typedef struct packed {
        logic              busy;
        logic [STEP_W-1:0] step;
    } t_seq_stat;

    // Microcode program of one regulation tick.
    function automatic t_uword urom(input logic [STEP_W-1:0] addr);
        t_uword w;
        w = '{op: OP_NOP, jmp: JMP_NEXT, target: '0};
        unique case (addr)
            4'd0:      w.op = OP_SPD;
            4'd1:      w.op = OP_ERR;
            4'd2:      w.op = OP_PE;
            4'd3:      w.op = OP_VSUM;
            4'd4:      w.op = OP_VDIV;
            4'd5:      w.op = OP_CLAMP;
            4'd6:      w.op = OP_TMUL;
            4'd7:      w.op = OP_MSUM;
            4'd8:      w.op = OP_DIV_INIT;
            STEP_DIV:  w = '{op: OP_DIV_STEP, jmp: JMP_LOOP_DIV, target: STEP_DIV};
            4'd10:     w.op = OP_INC;
            STEP_EMIT: w = '{op: OP_SAT, jmp: JMP_EMIT, target: STEP_EMIT};
            default:   w.op = OP_NOP;
        endcase
        return w;
    endfunction

endpackage

@@ hdl/qspr_useq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
// Depends on qspr_pkg.
module qspr_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_out_busy,
    input  qspr_pkg::t_dp_stat   i_dp_stat,
    output qspr_pkg::t_ctrl      o_ctrl,
    output qspr_pkg::t_seq_stat  o_stat
);

    logic                          r_busy;
    logic [qspr_pkg::STEP_W-1:0]   r_step;
    qspr_pkg::t_uword              w_word;
    logic                          w_hold;

    // Fetch the control word of the current step.
    assign w_word = qspr_pkg::urom(r_step);

    // The final step waits while the result register is full and stalled.
    assign w_hold = (w_word.jmp == qspr_pkg::JMP_EMIT) && i_out_busy;

    assign o_ctrl.fire = r_busy && !w_hold;
    assign o_ctrl.op   = r_busy ? w_word.op : qspr_pkg::OP_NOP;
    assign o_stat.busy = r_busy;
    assign o_stat.step = r_step;

    // Step counter and jump logic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end else begin
            unique case (w_word.jmp)
                qspr_pkg::JMP_NEXT: begin
                    r_step <= r_step + 1'b1;
                end
                qspr_pkg::JMP_LOOP_DIV: begin
                    r_step <= i_dp_stat.div_more ? w_word.target : r_step + 1'b1;
                end
                qspr_pkg::JMP_EMIT: begin
                    if (!i_out_busy) begin
                        r_busy <= 1'b0;
                        r_step <= '0;
                    end
                end
                default: begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                end
            endcase
        end
    end

endmodule

@@ hdl/qspr_dpath.sv @@
// Regulator datapath: speed scaling, PI arithmetic, a radix-2 divider and the integral.
// Depends on qspr_pkg; driven by the control words of qspr_useq.
module qspr_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qspr_pkg::t_ctrl               i_ctrl,
    input  logic [qspr_pkg::CNT_W-1:0]    i_pulse_count,
    input  logic [qspr_pkg::REG_W-1:0]    i_ref,
    input  logic [qspr_pkg::REG_W-1:0]    i_gain,
    input  logic [qspr_pkg::REG_W-1:0]    i_ti,
    output qspr_pkg::t_dp_stat            o_stat,
    output logic [qspr_pkg::REG_W-1:0]    o_drive,
    output logic [qspr_pkg::SPD_W-1:0]    o_speed
);

    localparam int FB = qspr_pkg::FRAC_BITS;

    logic        [qspr_pkg::SPD_W-1:0]   r_spd;
    logic signed [qspr_pkg::ERR_W-1:0]   r_err;
    logic signed [qspr_pkg::PE_W-1:0]    r_pe;
    logic signed [qspr_pkg::SUM_W-1:0]   r_sum;
    logic signed [qspr_pkg::V_W-1:0]     r_v;
    logic        [qspr_pkg::REG_W-1:0]   r_u;
    logic signed [qspr_pkg::D_W-1:0]     r_d;
    logic signed [qspr_pkg::TM_W-1:0]    r_tm;
    logic signed [qspr_pkg::M_W-1:0]     r_m;
    logic                                r_neg;
    logic        [qspr_pkg::DIV_W-1:0]   r_quo;
    logic        [qspr_pkg::DIVR_W-1:0]  r_rem;
    logic        [qspr_pkg::DCNT_W-1:0]  r_cnt;
    logic signed [qspr_pkg::ACC_W-1:0]   r_acc;
    logic signed [qspr_pkg::I_W-1:0]     r_integ;

    logic        [qspr_pkg::REG_W-1:0]   w_ti;
    logic        [qspr_pkg::DIVR_W-1:0]  w_divisor;
    logic        [qspr_pkg::PROD_W-1:0]  w_spd_prod;
    logic signed [qspr_pkg::SUM_W-1:0]   w_vfl;
    logic                                w_round;
    logic signed [qspr_pkg::SUM_W-1:0]   w_vq;
    logic        [qspr_pkg::REG_W-1:0]   w_u;
    logic        [qspr_pkg::M_W-1:0]     w_mag;
    logic        [qspr_pkg::DIVR_W:0]    w_shift;
    logic                                w_ge;
    logic        [qspr_pkg::DIVR_W:0]    w_diff;
    logic signed [qspr_pkg::ACC_W-1:0]   w_qs;
    logic signed [qspr_pkg::ACC_W-1:0]   w_inc;
    logic signed [qspr_pkg::I_W-1:0]     w_sat;
    logic signed [qspr_pkg::I_W-1:0]     w_imax;
    logic signed [qspr_pkg::I_W-1:0]     w_imin;

    // An integral time of zero acts as one; the divisor is TICK_RATE_HZ * Ti.
    assign w_ti      = (i_ti == '0) ? qspr_pkg::REG_W'(1) : i_ti;
    assign w_divisor = qspr_pkg::DIVR_W'(w_ti) * qspr_pkg::DIVR_W'(qspr_pkg::TICK_RATE_HZ);

    // Speed from the pulse count by a scaled reciprocal.
    assign w_spd_prod = qspr_pkg::PROD_W'(i_pulse_count) * qspr_pkg::PROD_W'(qspr_pkg::SPD_K);

    // Divide by 2^FRAC_BITS with truncation toward zero.
    assign w_vfl   = r_sum >>> FB;
    assign w_round = r_sum[qspr_pkg::SUM_W-1] && (r_sum[FB-1:0] != '0);
    assign w_vq    = w_vfl + $signed(qspr_pkg::SUM_W'(w_round));

    // Clamp the controller output to the drive range.
    always_comb begin
        if (r_v[qspr_pkg::V_W-1]) begin
            w_u = '0;
        end else if (r_v[qspr_pkg::V_W-2:qspr_pkg::REG_W] != '0) begin
            w_u = qspr_pkg::DRIVE_MAX;
        end else begin
            w_u = r_v[qspr_pkg::REG_W-1:0];
        end
    end

    // Magnitude of the integral numerator for the sign-magnitude divider.
    assign w_mag = r_m[qspr_pkg::M_W-1] ? qspr_pkg::M_W'(-r_m) : qspr_pkg::M_W'(r_m);

    // One restoring division step.
    assign w_shift = {r_rem, r_quo[qspr_pkg::DIV_W-1]};
    assign w_ge    = w_shift >= {1'b0, w_divisor};
    assign w_diff  = w_shift - {1'b0, w_divisor};

    // Signed quotient, truncated toward zero.
    assign w_qs  = $signed({2'b00, r_quo});
    assign w_inc = r_neg ? -w_qs : w_qs;

    // Saturate the new integral to 32 bits.
    assign w_imax = {1'b0, {(qspr_pkg::I_W-1){1'b1}}};
    assign w_imin = {1'b1, {(qspr_pkg::I_W-1){1'b0}}};
    always_comb begin
        if (r_acc > qspr_pkg::ACC_W'(w_imax)) begin
            w_sat = w_imax;
        end else if (r_acc < qspr_pkg::ACC_W'(w_imin)) begin
            w_sat = w_imin;
        end else begin
            w_sat = qspr_pkg::I_W'(r_acc);
        end
    end

    // Integral state, updated by the last step of a tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_ctrl.fire && (i_ctrl.op == qspr_pkg::OP_SAT)) begin
            r_integ <= w_sat;
        end
    end

    // Working registers; each operation loads its own.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            unique case (i_ctrl.op)
                qspr_pkg::OP_SPD: begin
                    r_spd <= w_spd_prod[qspr_pkg::SPD_SHIFT +: qspr_pkg::SPD_W];
                end
                qspr_pkg::OP_ERR: begin
                    r_err <= $signed({2'b00, i_ref}) - $signed({1'b0, r_spd});
                end
                qspr_pkg::OP_PE: begin
                    r_pe <= qspr_pkg::PE_W'(r_err) * qspr_pkg::PE_W'($signed({1'b0, i_gain}));
                end
                qspr_pkg::OP_VSUM: begin
                    r_sum <= (qspr_pkg::SUM_W'(r_pe) <<< FB) + qspr_pkg::SUM_W'(r_integ);
                end
                qspr_pkg::OP_VDIV: begin
                    r_v <= qspr_pkg::V_W'(w_vq);
                end
                qspr_pkg::OP_CLAMP: begin
                    r_u <= w_u;
                    r_d <= $signed({{(qspr_pkg::D_W-qspr_pkg::REG_W){1'b0}}, w_u})
                           - qspr_pkg::D_W'(r_v);
                end
                qspr_pkg::OP_TMUL: begin
                    r_tm <= qspr_pkg::TM_W'(r_d) * qspr_pkg::TM_W'($signed({1'b0, w_ti}));
                end
                qspr_pkg::OP_MSUM: begin
                    r_m <= qspr_pkg::M_W'(r_tm) + qspr_pkg::M_W'(r_pe);
                end
                qspr_pkg::OP_DIV_INIT: begin
                    r_neg <= r_m[qspr_pkg::M_W-1];
                    r_quo <= qspr_pkg::DIV_W'(w_mag) << FB;
                    r_rem <= '0;
                    r_cnt <= qspr_pkg::DCNT_W'(qspr_pkg::DIV_W);
                end
                qspr_pkg::OP_DIV_STEP: begin
                    r_rem <= w_ge ? w_diff[qspr_pkg::DIVR_W-1:0]
                                  : w_shift[qspr_pkg::DIVR_W-1:0];
                    r_quo <= {r_quo[qspr_pkg::DIV_W-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                end
                qspr_pkg::OP_INC: begin
                    r_acc <= qspr_pkg::ACC_W'(r_integ) + w_inc;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.div_more = (r_cnt != qspr_pkg::DCNT_W'(1));
    assign o_drive         = r_u;
    assign o_speed         = r_spd;

endmodule

@@ hdl/quadrature_speed_pi_regulator.sv @@
// Top level of the quadrature speed regulator: encoder counter, registers, result register.
// Depends on qspr_pkg, qspr_useq, qspr_dpath and the assertion macro header.
//
// An encoder sample moves the saturating pulse count when it is accepted.
// A regulation tick runs a short microcode program: speed, PI output with
// clamp, then the anti-windup integral update through a one-bit-per-cycle
// divider of 44 steps. The result is registered when the program ends
// (nine setup steps, the 44 divider steps and two closing steps), its run
// time set mostly by that divider loop, and the next request can be taken as
// soon as the result is registered; all of this stretches while the previous
// result has not been taken. Requests are not accepted while a tick is
// running. The result shows drive, speed and PWM compare value and stays until
// it is taken; the registers may be written whenever the block is idle.
`include "quadrature_speed_pi_regulator_assert.svh"

module quadrature_speed_pi_regulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qspr_pkg::CFGI_W-1:0]       i_cfg_index,
    input  logic [qspr_pkg::REG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [1:0]                        i_encoder_ab,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [qspr_pkg::REG_W-1:0]        o_drive,
    output logic [qspr_pkg::SPD_W-1:0]        o_speed_rpm,
    output logic [qspr_pkg::REG_W-1:0]        o_pwm_compare
);

    logic [qspr_pkg::REG_W-1:0]  r_ref;
    logic [qspr_pkg::REG_W-1:0]  r_gain;
    logic [qspr_pkg::REG_W-1:0]  r_ti;
    logic [1:0]                  r_prev_swapped;
    logic [qspr_pkg::CNT_W-1:0]  r_pulse_count;
    logic                        r_out_valid;
    logic [qspr_pkg::REG_W-1:0]  r_out_drive;
    logic [qspr_pkg::SPD_W-1:0]  r_out_speed;
    logic [qspr_pkg::REG_W-1:0]  r_out_pwm;

    logic                        w_in_acc;
    logic                        w_start;
    logic                        w_out_busy;
    logic                        w_emit;
    logic [1:0]                  w_edge;
    qspr_pkg::t_ctrl             w_ctrl;
    qspr_pkg::t_seq_stat         w_seq_stat;
    qspr_pkg::t_dp_stat          w_dp_stat;
    logic [qspr_pkg::REG_W-1:0]  w_drive;
    logic [qspr_pkg::SPD_W-1:0]  w_speed;

    // Input handshake: no request is taken while a tick is in progress.
    assign o_in_stall = w_seq_stat.busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_start    = w_in_acc && (i_opcode == qspr_pkg::OPC_TICK);

    // The result register is held when it is full and stalled.
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_emit     = w_ctrl.fire && (w_ctrl.op == qspr_pkg::OP_SAT);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= qspr_pkg::REF_RST;
            r_gain <= qspr_pkg::GAIN_RST;
            r_ti   <= qspr_pkg::TI_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qspr_pkg::CFG_REF:  r_ref  <= i_cfg_data;
                qspr_pkg::CFG_GAIN: r_gain <= i_cfg_data;
                qspr_pkg::CFG_TI:   r_ti   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Quadrature decoding against the stored, bit-swapped previous pair.
    assign w_edge = r_prev_swapped ^ i_encoder_ab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_swapped <= '0;
            r_pulse_count  <= '0;
        end else if (w_emit) begin
            r_pulse_count <= '0;
        end else if (w_in_acc && (i_opcode == qspr_pkg::OPC_SAMPLE)) begin
            r_prev_swapped <= {i_encoder_ab[0], i_encoder_ab[1]};
            if ((w_edge == qspr_pkg::QD_UP) && (r_pulse_count != '1)) begin
                r_pulse_count <= r_pulse_count + 1'b1;
            end else if ((w_edge == qspr_pkg::QD_DOWN) && (r_pulse_count != '0)) begin
                r_pulse_count <= r_pulse_count - 1'b1;
            end
        end
    end

    // Sequencer and datapath.
    qspr_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_busy (w_out_busy),
        .i_dp_stat  (w_dp_stat),
        .o_ctrl     (w_ctrl),
        .o_stat     (w_seq_stat)
    );

    qspr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_pulse_count (r_pulse_count),
        .i_ref         (r_ref),
        .i_gain        (r_gain),
        .i_ti          (r_ti),
        .o_stat        (w_dp_stat),
        .o_drive       (w_drive),
        .o_speed       (w_speed)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_drive <= w_drive;
            r_out_speed <= w_speed;
            r_out_pwm   <= qspr_pkg::DRIVE_MAX - w_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_out_drive;
    assign o_speed_rpm   = r_out_speed;
    assign o_pwm_compare = r_out_pwm;

    // Checks on sequencing and result handling.
    `QSPR_ASSERT_IMP(a_emit_needs_room, i_clk, i_rst_n, w_emit, !w_out_busy, "result overwritten while stalled")
    `QSPR_ASSERT_NXT(a_tick_starts_prog, i_clk, i_rst_n, w_start, w_seq_stat.busy && (w_seq_stat.step == '0), "tick did not start the program")
    `QSPR_ASSERT_NXT(a_emit_clears_count, i_clk, i_rst_n, w_emit, (r_pulse_count == '0) && o_out_valid, "pulse count not cleared at result")

endmodule
